FILE: sv/nns_pkg.sv
// Shared types and constants for the nearest-neighbor scaler.
// No dependencies; every other file but nns_ram refers to it by scoped name.
package nns_pkg;

  localparam int COORD_W    = 12;
  localparam int PIXEL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SRC_RAW_W  = 9;
  localparam int DST_RAW_W  = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // Classified request as it travels from front to back.
  typedef struct packed {
    logic               is_read;
    logic               oor;
    logic               frame_end;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] pixel;
  } item_t;

endpackage

FILE: sv/nns_if.sv
// Channel interfaces: request, result and configuration write.
// Depends on nns_pkg for field widths.
interface nns_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [nns_pkg::COORD_W-1:0] col;
  logic [nns_pkg::COORD_W-1:0] row;
  logic [nns_pkg::PIXEL_W-1:0] pixel_in;
  modport source (output valid, operation, col, row, pixel_in, input ready);
  modport sink   (input valid, operation, col, row, pixel_in, output ready);
endinterface

interface nns_res_if;
  logic                        valid;
  logic                        ready;
  logic [nns_pkg::PIXEL_W-1:0] pixel_out;
  logic                        out_of_range;
  logic                        frame_end;
  modport source (output valid, pixel_out, out_of_range, frame_end, input ready);
  modport sink   (input valid, pixel_out, out_of_range, frame_end, output ready);
endinterface

interface nns_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nns_pkg::CFG_IDX_W-1:0]  index;
  logic [nns_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/nearest_neighbour_scaler_core.sv
// Nearest-neighbor scaler, top level: configuration registers, front end,
// queue and back end. Depends on nns_pkg, nns_if, nns_front, nns_queue, nns_back.
//
// The block keeps a source frame of 32-bit pixels (MAX_SRC_WIDTH x
// MAX_SRC_HEIGHT words) and answers read requests for a destination window
// with the nearest source pixel, sx = floor(col*W/DW), sy = floor(row*H/DH).
// A write request (operation 0) stores one source pixel at col,row and gives
// no result; writes outside the configured source size are dropped. A read
// request (operation 1) gives exactly one result; a read outside the
// destination window returns out_of_range with pixel_out and frame_end at 0.
// Throughput is one request per clock while the queue is not full, reads
// and writes mixed freely, in order. A read passes through the queue, the
// divider, which resolves one quotient bit per pipeline stage of a QW-bit
// quotient, QW = clog2(max(MAX_SRC_WIDTH, MAX_SRC_HEIGHT)) (QW is 8 at the
// defaults), then the address multiply and the registered frame store read.
// A two-entry queue decouples request intake from the back pipeline, so
// request.ready stays high while a result waits on result.ready until the
// queue fills. Size registers are written through cfg (always ready) while
// the block is idle, a user rule that the block does not enforce. 0 is
// taken as 1 and values above the maximum saturate; source sizes come from
// the low 9 data bits. The frame store is not cleared; read only pixels
// that were written, with the same source width as when they were loaded.
module nearest_neighbour_scaler_core #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_DIM    = 4096
) (
  input  logic      clk,
  input  logic      rst,
  nns_req_if.sink   request,
  nns_res_if.source result,
  nns_cfg_if.sink   cfg
);

  localparam int SW_W = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SH_W = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int DD_W = $clog2(MAX_DST_DIM + 1);

  // effective (clamped) sizes
  logic [SW_W-1:0] w;
  logic [SH_W-1:0] h;
  logic [DD_W-1:0] dw;
  logic [DD_W-1:0] dh;

  logic [nns_pkg::SRC_RAW_W-1:0] src_raw;
  logic [nns_pkg::DST_RAW_W-1:0] dst_raw;
  logic [SW_W-1:0]               w_next;
  logic [SH_W-1:0]               h_next;
  logic [DD_W-1:0]               d_next;

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  nns_pkg::item_t push_item;
  nns_pkg::item_t head;

  assign cfg.ready = 1'b1;

  // clamp written size to 1..max at write time
  always_comb begin
    src_raw = cfg.data[nns_pkg::SRC_RAW_W-1:0];
    dst_raw = cfg.data[nns_pkg::DST_RAW_W-1:0];
    if (src_raw == '0) begin
      w_next = SW_W'(1);
      h_next = SH_W'(1);
    end else begin
      w_next = (int'(src_raw) > MAX_SRC_WIDTH)  ? SW_W'(MAX_SRC_WIDTH)  : SW_W'(src_raw);
      h_next = (int'(src_raw) > MAX_SRC_HEIGHT) ? SH_W'(MAX_SRC_HEIGHT) : SH_W'(src_raw);
    end
    if (dst_raw == '0) begin
      d_next = DD_W'(1);
    end else begin
      d_next = (int'(dst_raw) > MAX_DST_DIM) ? DD_W'(MAX_DST_DIM) : DD_W'(dst_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w  <= SW_W'(1);
      h  <= SH_W'(1);
      dw <= DD_W'(1);
      dh <= DD_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        nns_pkg::REG_SRC_WIDTH: begin
          w <= w_next;
        end
        nns_pkg::REG_SRC_HEIGHT: begin
          h <= h_next;
        end
        nns_pkg::REG_DST_WIDTH: begin
          dw <= d_next;
        end
        nns_pkg::REG_DST_HEIGHT: begin
          dh <= d_next;
        end
        default: begin
        end
      endcase
    end
  end

  nns_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_DST_DIM    (MAX_DST_DIM)
  ) u_front (
    .request   (request),
    .w         (w),
    .h         (h),
    .dw        (dw),
    .dh        (dh),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  nns_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  nns_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_DST_DIM    (MAX_DST_DIM)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (head),
    .q_pop   (pop),
    .w       (w),
    .h       (h),
    .dw      (dw),
    .dh      (dh),
    .result  (result)
  );

endmodule

FILE: sv/nns_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module nns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/nns_front.sv
// Front end: accepts requests, drops writes outside the source frame and
// flags reads outside the destination window. Depends on nns_pkg, nns_if.
module nns_front #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_DIM    = 4096
) (
  nns_req_if.sink                             request,
  input  logic [$clog2(MAX_SRC_WIDTH+1)-1:0]  w,
  input  logic [$clog2(MAX_SRC_HEIGHT+1)-1:0] h,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]    dw,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]    dh,
  input  logic                                q_full,
  output logic                                push,
  output nns_pkg::item_t                      push_item
);

  logic is_read;
  logic in_src;
  logic oor;
  logic last;

  always_comb begin
    is_read = (request.operation == nns_pkg::OP_READ);
    in_src  = (32'(request.col) < 32'(w)) && (32'(request.row) < 32'(h));
    oor     = (32'(request.col) >= 32'(dw)) || (32'(request.row) >= 32'(dh));
    last    = (32'(request.col) == 32'(dw) - 32'd1) &&
              (32'(request.row) == 32'(dh) - 32'd1);
  end

  assign request.ready = !q_full;
  // writes outside the source are taken and dropped here
  assign push = request.valid && !q_full && (is_read || in_src);

  always_comb begin
    push_item.is_read   = is_read;
    push_item.oor       = is_read && oor;
    push_item.frame_end = is_read && !oor && last;
    push_item.col       = request.col;
    push_item.row       = request.row;
    push_item.pixel     = request.pixel_in;
  end

endmodule

FILE: sv/nns_queue.sv
// Two-entry queue between front and back, so each side stalls on its own.
// Depends on nns_pkg for the item type.
module nns_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nns_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output nns_pkg::item_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nns_pkg::item_t   mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_reset_empty: assert property (@(posedge clk) rst |=> (count == '0) && (wr_ptr == rd_ptr))
    else $error("queue not empty after reset");
`endif

endmodule

FILE: sv/nns_back.sv
// Back end: pipelined coordinate divider, address multiply, frame store
// access and result register. Depends on nns_pkg, nns_if, nns_ram.
module nns_back #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_DIM    = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  nns_pkg::item_t                      q_head,
  output logic                                q_pop,
  input  logic [$clog2(MAX_SRC_WIDTH+1)-1:0]  w,
  input  logic [$clog2(MAX_SRC_HEIGHT+1)-1:0] h,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]    dw,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]    dh,
  nns_res_if.source                           result
);

  localparam int SW_W = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SH_W = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int DD_W = $clog2(MAX_DST_DIM + 1);
  localparam int XW   = $clog2(MAX_SRC_WIDTH);
  localparam int YW   = $clog2(MAX_SRC_HEIGHT);
  localparam int QW   = (XW > YW) ? XW : YW;
  localparam int NXW  = nns_pkg::COORD_W + SW_W;
  localparam int NYW  = nns_pkg::COORD_W + SH_W;
  localparam int NW   = (NXW > NYW) ? NXW : NYW;
  localparam int RW   = (NW > DD_W + QW) ? NW : DD_W + QW;
  localparam int PW   = YW + SW_W;
  localparam int AW   = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);

  logic adv;

  // divider stages: stage 0 holds the products, stage k has k quotient bits
  logic [QW:0]     sv;
  nns_pkg::item_t  sitem [0:QW];
  logic [RW-1:0]   rx    [0:QW];
  logic [RW-1:0]   ry    [0:QW];
  logic [QW-1:0]   qx    [0:QW];
  logic [QW-1:0]   qy    [0:QW];
  logic [RW-1:0]   rx_next [0:QW-1];
  logic [RW-1:0]   ry_next [0:QW-1];
  logic [QW-1:0]   qx_next [0:QW-1];
  logic [QW-1:0]   qy_next [0:QW-1];
  logic [RW-1:0]   dxs   [0:QW-1];
  logic [RW-1:0]   dys   [0:QW-1];

  // address stage
  logic            va;
  nns_pkg::item_t  itema;
  logic [PW-1:0]   prod_a;
  logic [XW-1:0]   sx_a;
  logic [XW-1:0]   sx_sel;
  logic [YW-1:0]   sy_sel;
  logic [AW-1:0]   addr;

  // result stage
  logic                        vr;
  logic                        oor_r;
  logic                        fe_r;
  logic [nns_pkg::PIXEL_W-1:0] rdata;

  assign adv   = !vr || result.ready;
  assign q_pop = adv && !q_empty;

  // one restoring step per stage, shifted divisor set by the stage position
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      dxs[k]     = RW'(dw) << (QW - 1 - k);
      dys[k]     = RW'(dh) << (QW - 1 - k);
      rx_next[k] = rx[k];
      ry_next[k] = ry[k];
      qx_next[k] = qx[k];
      qy_next[k] = qy[k];
      if (rx[k] >= dxs[k]) begin
        rx_next[k]             = rx[k] - dxs[k];
        qx_next[k][QW - 1 - k] = 1'b1;
      end
      if (ry[k] >= dys[k]) begin
        ry_next[k]             = ry[k] - dys[k];
        qy_next[k][QW - 1 - k] = 1'b1;
      end
    end
  end

  // quotient is below the source size for any in-range read, so no clamp
  always_comb begin
    sx_sel = sitem[QW].is_read ? qx[QW][XW-1:0] : sitem[QW].col[XW-1:0];
    sy_sel = sitem[QW].is_read ? qy[QW][YW-1:0] : sitem[QW].row[YW-1:0];
    addr   = AW'(prod_a + PW'(sx_a));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
      va <= 1'b0;
      vr <= 1'b0;
    end else if (adv) begin
      sv[0] <= !q_empty;
      for (int k = 0; k < QW; k++) begin
        sv[k+1] <= sv[k];
      end
      va <= sv[QW];
      vr <= va && itema.is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sitem[0] <= q_head;
      rx[0]    <= RW'(q_head.col) * RW'(w);
      ry[0]    <= RW'(q_head.row) * RW'(h);
      qx[0]    <= '0;
      qy[0]    <= '0;
      for (int k = 0; k < QW; k++) begin
        sitem[k+1] <= sitem[k];
        rx[k+1]    <= rx_next[k];
        ry[k+1]    <= ry_next[k];
        qx[k+1]    <= qx_next[k];
        qy[k+1]    <= qy_next[k];
      end
      itema  <= sitem[QW];
      prod_a <= PW'(sy_sel) * PW'(w);
      sx_a   <= sx_sel;
      oor_r  <= itema.oor;
      fe_r   <= itema.frame_end;
    end
  end

  nns_ram #(
    .WIDTH (nns_pkg::PIXEL_W),
    .DEPTH (MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
  ) u_frame_store (
    .clk   (clk),
    .we    (adv && va && !itema.is_read),
    .waddr (addr),
    .wdata (itema.pixel),
    .re    (adv),
    .raddr (addr),
    .rdata (rdata)
  );

  assign result.valid        = vr;
  assign result.pixel_out    = oor_r ? '0 : rdata;
  assign result.out_of_range = oor_r;
  assign result.frame_end    = fe_r;

endmodule
